>>> hdl/ogm_pkg.sv
package ogm_pkg;

   localparam int COORD_W  = 24;
   localparam int MARGIN_W = 23;
   localparam int DIR_W    = 16;
   localparam int DELTA_W  = 32;
   localparam int BND_W    = 26;   // bounds and half extents
   localparam int MAG_W    = 31;   // normalized offset magnitude
   localparam int RAD_W    = 63;   // sum of squares
   localparam int ROOT_W   = 32;
   localparam int NUM_W    = 48;   // divider partial remainder
   localparam int DVS_W    = 33;
   localparam int QUO_W    = 16;

   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 23'd256;
   localparam logic [QUO_W-1:0]    DIR_ONE      = 16'd16384;

   localparam logic [1:0] KIND_HIDDEN = 2'd0;
   localparam logic [1:0] KIND_ARROW  = 2'd1;
   localparam logic [1:0] KIND_OTHER  = 2'd2;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [COORD_W-1:0] mx;
      logic signed [COORD_W-1:0] my;
      logic [DELTA_W-1:0]        delta;
      logic                      dvalid;
      logic signed [COORD_W-1:0] vl;
      logic signed [COORD_W-1:0] vt;
      logic signed [COORD_W-1:0] vr;
      logic signed [COORD_W-1:0] vb;
      logic signed [COORD_W-1:0] tx;
      logic signed [COORD_W-1:0] ty;
      logic signed [BND_W-1:0]   lox;
      logic signed [BND_W-1:0]   hix;
      logic signed [BND_W-1:0]   loy;
      logic signed [BND_W-1:0]   hiy;
      logic                      negx;
      logic                      negy;
      logic                      nz;
      logic [MAG_W-1:0]          ax;
      logic [MAG_W-1:0]          ay;
      logic [RAD_W-1:0]          rem;
      logic [ROOT_W-1:0]         root;
      logic [NUM_W-1:0]          px;
      logic [NUM_W-1:0]          py;
      logic [DVS_W-1:0]          dvs;
      logic [QUO_W-1:0]          qx;
      logic [QUO_W-1:0]          qy;
   } pipe_type;

endpackage

>>> hdl/ogm_stage.sv
module ogm_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ogm_pkg::pipe_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output ogm_pkg::pipe_type out_data,
   input  logic              out_ready
);
   import ogm_pkg::*;

   logic     valid_ff;
   pipe_type data_ff;

   // stage refills when empty or when its beat moves on
   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

>>> hdl/ogm_norm_cell.sv
module ogm_norm_cell #(
   parameter int SHIFT = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ogm_pkg::pipe_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output ogm_pkg::pipe_type out_data,
   input  logic              out_ready
);
   import ogm_pkg::*;

   pipe_type        nxt;
   logic [MAG_W-1:0] big;

   always_comb begin
      nxt = in_data;
      big = in_data.ax | in_data.ay;
      if (big[MAG_W-1 -: SHIFT] == '0) begin
         nxt.ax = in_data.ax << SHIFT;
         nxt.ay = in_data.ay << SHIFT;
      end
   end

   ogm_stage u_stage (
      .clock(clock), .reset(reset),
      .in_valid(in_valid), .in_data(nxt), .in_ready(in_ready),
      .out_valid(out_valid), .out_data(out_data), .out_ready(out_ready)
   );

endmodule

>>> hdl/ogm_sqrt_cell.sv
module ogm_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ogm_pkg::pipe_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output ogm_pkg::pipe_type out_data,
   input  logic              out_ready
);
   import ogm_pkg::*;

   localparam int TW = RAD_W + 3;

   pipe_type        nxt;
   logic [TW-1:0]   trial;

   // (root + 2^i)^2 - root^2 = root*2^(i+1) + 2^(2i)
   always_comb begin
      nxt   = in_data;
      trial = ({{(TW-ROOT_W){1'b0}}, in_data.root} << (BIT + 1))
            + ({{(TW-1){1'b0}}, 1'b1} << (2 * BIT));
      if ({3'b000, in_data.rem} >= trial) begin
         nxt.rem       = in_data.rem - trial[RAD_W-1:0];
         nxt.root[BIT] = 1'b1;
      end
   end

   ogm_stage u_stage (
      .clock(clock), .reset(reset),
      .in_valid(in_valid), .in_data(nxt), .in_ready(in_ready),
      .out_valid(out_valid), .out_data(out_data), .out_ready(out_ready)
   );

endmodule

>>> hdl/ogm_div_cell.sv
module ogm_div_cell #(
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ogm_pkg::pipe_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output ogm_pkg::pipe_type out_data,
   input  logic              out_ready
);
   import ogm_pkg::*;

   localparam int DW = NUM_W + 1;

   pipe_type      nxt;
   logic [DW-1:0] dd;

   always_comb begin
      nxt = in_data;
      dd  = {{(DW-DVS_W){1'b0}}, in_data.dvs} << BIT;
      if ({1'b0, in_data.px} >= dd) begin
         nxt.px      = in_data.px - dd[NUM_W-1:0];
         nxt.qx[BIT] = 1'b1;
      end
      if ({1'b0, in_data.py} >= dd) begin
         nxt.py      = in_data.py - dd[NUM_W-1:0];
         nxt.qy[BIT] = 1'b1;
      end
   end

   ogm_stage u_stage (
      .clock(clock), .reset(reset),
      .in_valid(in_valid), .in_data(nxt), .in_ready(in_ready),
      .out_valid(out_valid), .out_data(out_data), .out_ready(out_ready)
   );

endmodule

>>> hdl/offscreen_marker_geometry_unit.sv
// Throughput: one beat per cycle unless rsp_tready stalls the chain; every
// stage is a registered cell and the chain holds up to 59 beats in flight
// (3 geometry, 5 normalize, 1 square, 32 root, 1 divider setup, 16 divide,
// 1 output register). Reset (synchronous, active high) empties the chain
// and sets edge_margin to 256 (16.0 in Q19.4). No memories, no clearing pass.
module offscreen_marker_geometry_unit (
   input  logic          clock,
   input  logic          reset,
   // csr write channel: edge_margin
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [22:0]   csr_data,
   // req_tdata: view_left, view_top, view_right, view_bottom,
   //            target_x, target_y, time_delta
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [175:0]  req_tdata,
   // req_tuser: same_area, delta_valid
   input  logic [1:0]    req_tuser,
   // rsp_tdata: marker_x, marker_y, dir_x, dir_y, time_delta_out
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,
   // rsp_tuser: marker_kind (2 bits), delta_valid_out
   output logic [2:0]    rsp_tuser
);
   import ogm_pkg::*;

   localparam int N_FRONT = 3;
   localparam int N_NORM  = 5;
   localparam int N_ROOT  = ROOT_W;
   localparam int N_DIV   = QUO_W;
   localparam int P_NORM  = N_FRONT;             // first normalize cell
   localparam int P_SQ    = P_NORM + N_NORM;     // square stage
   localparam int P_ROOT  = P_SQ + 1;            // first root cell
   localparam int P_PREP  = P_ROOT + N_ROOT;     // divider setup
   localparam int P_DIV   = P_PREP + 1;          // first divide cell
   localparam int P_OUT   = P_DIV + N_DIV;       // output register
   localparam int N_STG   = P_OUT + 1;

   logic [MARGIN_W-1:0] margin_ff;

   // chain nodes: node i feeds stage i
   logic     nv [0:N_STG];
   logic     nr [0:N_STG];
   pipe_type nd [0:N_STG];

   // ---------------- edge_margin register ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_valid) begin
         margin_ff <= csr_data;
      end
   end

   // ---------------- front stage 1: classify, offsets ----------------
   pipe_type                  f1;
   logic signed [COORD_W:0]   sumx, sumy, wid, hgt;
   logic signed [COORD_W+2:0] ox, oy;
   logic                      in_view;

   always_comb begin
      f1        = '0;
      f1.vl     = req_tdata[23:0];
      f1.vt     = req_tdata[47:24];
      f1.vr     = req_tdata[71:48];
      f1.vb     = req_tdata[95:72];
      f1.tx     = req_tdata[119:96];
      f1.ty     = req_tdata[143:120];
      f1.delta  = req_tdata[175:144];
      f1.dvalid = req_tuser[1];
      sumx = {f1.vl[COORD_W-1], f1.vl} + {f1.vr[COORD_W-1], f1.vr};
      sumy = {f1.vt[COORD_W-1], f1.vt} + {f1.vb[COORD_W-1], f1.vb};
      wid  = {f1.vr[COORD_W-1], f1.vr} - {f1.vl[COORD_W-1], f1.vl};
      hgt  = {f1.vb[COORD_W-1], f1.vb} - {f1.vt[COORD_W-1], f1.vt};
      // doubled offsets from the center, exact
      ox = {{2{f1.tx[COORD_W-1]}}, f1.tx, 1'b0} - {{2{sumx[COORD_W]}}, sumx};
      oy = {{2{f1.ty[COORD_W-1]}}, f1.ty, 1'b0} - {{2{sumy[COORD_W]}}, sumy};
      f1.negx = ox[COORD_W+2];
      f1.negy = oy[COORD_W+2];
      f1.ax   = {{(MAG_W-COORD_W-2){1'b0}},
                 ox[COORD_W+2] ? (COORD_W+2)'(0) - ox[COORD_W+1:0] : ox[COORD_W+1:0]};
      f1.ay   = {{(MAG_W-COORD_W-2){1'b0}},
                 oy[COORD_W+2] ? (COORD_W+2)'(0) - oy[COORD_W+1:0] : oy[COORD_W+1:0]};
      f1.nz   = (ox != '0) || (oy != '0);
      // half extents, floored; refined into bounds in stage 2
      f1.lox  = {wid[COORD_W], wid[COORD_W], wid[COORD_W:1]} >>> 0;
      f1.loy  = {hgt[COORD_W], hgt[COORD_W], hgt[COORD_W:1]} >>> 0;
      in_view = (f1.tx >= f1.vl) && (f1.tx < f1.vr) &&
                (f1.ty >= f1.vt) && (f1.ty < f1.vb);
      if (!req_tuser[0]) begin
         // other area: top center, no delta
         f1.kind   = KIND_OTHER;
         f1.mx     = sumx[COORD_W:1];
         f1.my     = f1.vt;
         f1.delta  = '0;
         f1.dvalid = 1'b0;
      end else if (in_view) begin
         f1.kind = KIND_HIDDEN;
         f1.mx   = f1.tx;
         f1.my   = f1.ty;
      end else begin
         f1.kind = KIND_ARROW;
      end
   end

   assign nv[0]      = req_tvalid;
   assign nd[0]      = f1;
   assign req_tready = nr[0];

   ogm_stage u_front1 (
      .clock(clock), .reset(reset),
      .in_valid(nv[0]), .in_data(nd[0]), .in_ready(nr[0]),
      .out_valid(nv[1]), .out_data(nd[1]), .out_ready(nr[1])
   );

   // ---------------- front stage 2: inset and bounds ----------------
   pipe_type                f2;
   logic signed [BND_W-1:0] mg, mgx, mgy;

   always_comb begin
      f2    = nd[1];
      mg    = {{(BND_W-MARGIN_W){1'b0}}, margin_ff};
      mgx   = (mg < nd[1].lox) ? mg : nd[1].lox;
      mgy   = (mg < nd[1].loy) ? mg : nd[1].loy;
      f2.lox = {{2{nd[1].vl[COORD_W-1]}}, nd[1].vl} + mgx;
      f2.hix = {{2{nd[1].vr[COORD_W-1]}}, nd[1].vr} - mgx;
      f2.loy = {{2{nd[1].vt[COORD_W-1]}}, nd[1].vt} + mgy;
      f2.hiy = {{2{nd[1].vb[COORD_W-1]}}, nd[1].vb} - mgy;
   end

   ogm_stage u_front2 (
      .clock(clock), .reset(reset),
      .in_valid(nv[1]), .in_data(f2), .in_ready(nr[1]),
      .out_valid(nv[2]), .out_data(nd[2]), .out_ready(nr[2])
   );

   // ---------------- front stage 3: clamp (low bound checked first) ----
   pipe_type                f3;
   logic signed [BND_W-1:0] ctx, cty, clx, cly;

   always_comb begin
      f3  = nd[2];
      ctx = {{2{nd[2].tx[COORD_W-1]}}, nd[2].tx};
      cty = {{2{nd[2].ty[COORD_W-1]}}, nd[2].ty};
      if (ctx < nd[2].lox)       clx = nd[2].lox;
      else if (ctx > nd[2].hix)  clx = nd[2].hix;
      else                       clx = ctx;
      if (cty < nd[2].loy)       cly = nd[2].loy;
      else if (cty > nd[2].hiy)  cly = nd[2].hiy;
      else                       cly = cty;
      if (nd[2].kind == KIND_ARROW) begin
         f3.mx = clx[COORD_W-1:0];
         f3.my = cly[COORD_W-1:0];
      end
   end

   ogm_stage u_front3 (
      .clock(clock), .reset(reset),
      .in_valid(nv[2]), .in_data(f3), .in_ready(nr[2]),
      .out_valid(nv[3]), .out_data(nd[3]), .out_ready(nr[3])
   );

   // ---------------- normalize: shift by 16, 8, 4, 2, 1 ----------------
   genvar g;
   generate
      for (g = 0; g < N_NORM; g++) begin : g_norm
         ogm_norm_cell #(.SHIFT(1 << (N_NORM - 1 - g))) u_cell (
            .clock(clock), .reset(reset),
            .in_valid(nv[P_NORM+g]), .in_data(nd[P_NORM+g]),
            .in_ready(nr[P_NORM+g]),
            .out_valid(nv[P_NORM+g+1]), .out_data(nd[P_NORM+g+1]),
            .out_ready(nr[P_NORM+g+1])
         );
      end
   endgenerate

   // ---------------- square: ax^2 + ay^2 ----------------
   pipe_type               fsq;
   logic [2*MAG_W-1:0]     sqx, sqy;

   always_comb begin
      fsq      = nd[P_SQ];
      sqx      = nd[P_SQ].ax * nd[P_SQ].ax;
      sqy      = nd[P_SQ].ay * nd[P_SQ].ay;
      fsq.rem  = {1'b0, sqx} + {1'b0, sqy};
      fsq.root = '0;
   end

   ogm_stage u_square (
      .clock(clock), .reset(reset),
      .in_valid(nv[P_SQ]), .in_data(fsq), .in_ready(nr[P_SQ]),
      .out_valid(nv[P_SQ+1]), .out_data(nd[P_SQ+1]), .out_ready(nr[P_SQ+1])
   );

   // ---------------- integer root, one result bit per cell ----------------
   generate
      for (g = 0; g < N_ROOT; g++) begin : g_root
         ogm_sqrt_cell #(.BIT(N_ROOT - 1 - g)) u_cell (
            .clock(clock), .reset(reset),
            .in_valid(nv[P_ROOT+g]), .in_data(nd[P_ROOT+g]),
            .in_ready(nr[P_ROOT+g]),
            .out_valid(nv[P_ROOT+g+1]), .out_data(nd[P_ROOT+g+1]),
            .out_ready(nr[P_ROOT+g+1])
         );
      end
   endgenerate

   // ---------------- divider setup: (a*32768 + r) / (2r) ----------------
   pipe_type fpr;

   always_comb begin
      fpr     = nd[P_PREP];
      fpr.px  = {2'b00, nd[P_PREP].ax, 15'd0} + {16'd0, nd[P_PREP].root};
      fpr.py  = {2'b00, nd[P_PREP].ay, 15'd0} + {16'd0, nd[P_PREP].root};
      fpr.dvs = {nd[P_PREP].root, 1'b0};
      fpr.qx  = '0;
      fpr.qy  = '0;
   end

   ogm_stage u_prep (
      .clock(clock), .reset(reset),
      .in_valid(nv[P_PREP]), .in_data(fpr), .in_ready(nr[P_PREP]),
      .out_valid(nv[P_PREP+1]), .out_data(nd[P_PREP+1]),
      .out_ready(nr[P_PREP+1])
   );

   // ---------------- restoring divide, one quotient bit per cell ----------
   generate
      for (g = 0; g < N_DIV; g++) begin : g_div
         ogm_div_cell #(.BIT(N_DIV - 1 - g)) u_cell (
            .clock(clock), .reset(reset),
            .in_valid(nv[P_DIV+g]), .in_data(nd[P_DIV+g]),
            .in_ready(nr[P_DIV+g]),
            .out_valid(nv[P_DIV+g+1]), .out_data(nd[P_DIV+g+1]),
            .out_ready(nr[P_DIV+g+1])
         );
      end
   endgenerate

   // ---------------- output register: clamp, sign, zero cases ------------
   pipe_type         fo;
   logic [QUO_W-1:0] mqx, mqy;

   always_comb begin
      fo  = nd[P_OUT];
      mqx = (nd[P_OUT].qx > DIR_ONE) ? DIR_ONE : nd[P_OUT].qx;
      mqy = (nd[P_OUT].qy > DIR_ONE) ? DIR_ONE : nd[P_OUT].qy;
      if (nd[P_OUT].kind == KIND_ARROW && nd[P_OUT].nz) begin
         fo.qx = nd[P_OUT].negx ? QUO_W'(0) - mqx : mqx;
         fo.qy = nd[P_OUT].negy ? QUO_W'(0) - mqy : mqy;
      end else begin
         // hidden, other area, or zero-length offset
         fo.qx = '0;
         fo.qy = '0;
      end
   end

   ogm_stage u_out (
      .clock(clock), .reset(reset),
      .in_valid(nv[P_OUT]), .in_data(fo), .in_ready(nr[P_OUT]),
      .out_valid(nv[N_STG]), .out_data(nd[N_STG]), .out_ready(nr[N_STG])
   );

   assign nr[N_STG]  = rsp_tready;
   assign rsp_tvalid = nv[N_STG];
   assign rsp_tdata  = {nd[N_STG].delta, nd[N_STG].qy, nd[N_STG].qx,
                        nd[N_STG].my, nd[N_STG].mx};
   assign rsp_tuser  = {nd[N_STG].dvalid, nd[N_STG].kind};

endmodule
